>>> design/ppms_pkg.sv
// ---------------------------------------------------------------------------
// Pure-pursuit motion step package
// Shared constants, register indexes and helper functions.
// ---------------------------------------------------------------------------
package ppms_pkg;

    localparam int CORDIC_STAGES = 16;

    // Internal datapath widths: positions differ by up to 2^33, CORDIC growth
    // needs a further two bits plus a sign.
    localparam int VW = 36;
    localparam int ZW = 28;

    localparam logic signed [ZW-1:0] PI24     = 28'sd52707179;
    localparam logic signed [ZW-1:0] HALFPI24 = 28'sd26353589;
    localparam logic signed [ZW:0]   TWOPI24  = 29'sd105414357;
    localparam logic signed [15:0]   HALFPI_Q13 = 16'sd12868;
    localparam logic [31:0]          INV_GAIN = 32'h9B74EDA8;

    localparam logic [20:0] STOP_DISTANCE_RST   = 21'd3277;
    localparam logic [15:0] CRUISE_SPEED_RST    = 16'd819;
    localparam logic [14:0] TURN_RATE_LIMIT_RST = 15'd4915;

    localparam logic [1:0] REG_STOP_DISTANCE   = 2'd0;
    localparam logic [1:0] REG_CRUISE_SPEED    = 2'd1;
    localparam logic [1:0] REG_TURN_RATE_LIMIT = 2'd2;

    localparam logic [1:0] KIND_STOP    = 2'd0;
    localparam logic [1:0] KIND_FORWARD = 2'd1;
    localparam logic [1:0] KIND_CCW     = 2'd2;
    localparam logic [1:0] KIND_CW      = 2'd3;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0: r = 28'sd13176795;
            1: r = 28'sd7778716;
            2: r = 28'sd4110060;
            3: r = 28'sd2086331;
            4: r = 28'sd1047214;
            5: r = 28'sd524117;
            6: r = 28'sd262123;
            7: r = 28'sd131069;
            default: r = ZW'(28'sd65536 >>> (i - 8));
        endcase
        return r;
    endfunction

    // Gain removal on a magnitude of at most 35 bits, floors as in the spec.
    function automatic logic [34:0] unscale(input logic [34:0] u);
        logic [50:0] hi;
        logic [47:0] lo;
        logic [51:0] s;
        hi = 51'(u[34:16]) * 51'(INV_GAIN);
        lo = 48'(u[15:0]) * 48'(INV_GAIN);
        s  = 52'(hi) + 52'(lo[47:16]);
        return 35'(s >> 16);
    endfunction

endpackage

>>> design/ppms_if.sv
// ---------------------------------------------------------------------------
// Pure-pursuit channel interfaces
// Valid/ready channels for pose items and motion results.
// ---------------------------------------------------------------------------
interface ppms_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] heading;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;

    modport source (output valid, pose_x, pose_y, heading, target_x, target_y,
                    input ready);
    modport sink (input valid, pose_x, pose_y, heading, target_x, target_y,
                  output ready);
endinterface

interface ppms_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         motion_kind;
    logic signed [31:0] signed_distance;
    logic signed [15:0] bearing_error;
    logic signed [15:0] forward_speed;
    logic signed [15:0] turn_speed;

    modport source (output valid, motion_kind, signed_distance, bearing_error,
                    forward_speed, turn_speed, input ready);
    modport sink (input valid, motion_kind, signed_distance, bearing_error,
                  forward_speed, turn_speed, output ready);
endinterface

>>> design/ppms_div.sv
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; quotient truncated to 63 bits of interest.
// ---------------------------------------------------------------------------
module ppms_div
    import ppms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [62:0] num,
    input  logic [61:0] den,
    output logic        out_valid,
    output logic [62:0] quo
);
    localparam int NB = 63;

    logic [NB-1:0] vld_reg;
    logic [NB-1:0] num_reg [NB];
    logic [61:0]   den_reg [NB];
    logic [62:0]   rem_reg [NB];

    logic [62:0] rem_in [NB];
    logic [NB-1:0] num_in [NB];
    logic [61:0] den_in [NB];
    logic [63:0] trial [NB];

    always_comb
    begin
        for (int s = 0; s < NB; s++)
        begin
            if (s == 0)
            begin
                rem_in[s] = '0;
                num_in[s] = num;
                den_in[s] = den;
            end
            else
            begin
                rem_in[s] = rem_reg[s-1];
                num_in[s] = num_reg[s-1];
                den_in[s] = den_reg[s-1];
            end
            trial[s] = {rem_in[s], num_in[s][NB-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NB-2:0], in_valid};
        end
    end

    // num_reg holds the remaining dividend bits shifted up, with quotient
    // bits shifted into the bottom.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NB; s++)
            begin
                den_reg[s] <= den_in[s];
                if (trial[s] >= {2'b00, den_in[s]})
                begin
                    rem_reg[s] <= 63'(trial[s] - {2'b00, den_in[s]});
                    num_reg[s] <= {num_in[s][NB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s] <= 63'(trial[s]);
                    num_reg[s] <= {num_in[s][NB-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[NB-1];
    assign quo       = num_reg[NB-1];
endmodule

>>> design/pure_pursuit_motion_step_core.sv
// ---------------------------------------------------------------------------
// Pure-pursuit motion step core
// Distance, bearing, motion kind and velocity command per pose item.
// ---------------------------------------------------------------------------
// One item enters per cycle while the output is not stalled:
// two CORDIC engines of CORDIC_STAGES stages run side by side, followed by
// gain removal, normalization, a squaring stage and a 63-stage bit-per-stage
// divider. With the input stage and the output register that makes
// CORDIC_STAGES + 68 register stages (84 with 16 CORDIC stages). A stall on
// the output freezes the whole pipeline, so throughput is one transaction
// per cycle while the sink takes.
module pure_pursuit_motion_step_core
    import ppms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ppms_in_if.sink     in_ch,
    ppms_out_if.source  out_ch
);
    localparam int NS = CORDIC_STAGES;

    typedef struct packed {
        logic                 v;
        logic signed [VW-1:0] x, y, rx, ry;
        logic signed [ZW-1:0] z, rz;
        logic signed [15:0]   h;
    } cst_t;

    // ---------------- configuration ----------------
    logic [20:0] stop_distance_reg;
    logic [15:0] cruise_speed_reg;
    logic [14:0] turn_rate_limit_reg;
    logic [1:0]  reg_idx;
    logic        addr_ok;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign addr_ok = (paddr[1:0] == 2'b00);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_distance_reg   <= STOP_DISTANCE_RST;
            cruise_speed_reg    <= CRUISE_SPEED_RST;
            turn_rate_limit_reg <= TURN_RATE_LIMIT_RST;
        end
        else if (psel && penable && pwrite && addr_ok)
        begin
            case (reg_idx)
                REG_STOP_DISTANCE:   stop_distance_reg   <= pwdata[20:0];
                REG_CRUISE_SPEED:    cruise_speed_reg    <= pwdata[15:0];
                REG_TURN_RATE_LIMIT: turn_rate_limit_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (addr_ok)
        begin
            case (reg_idx)
                REG_STOP_DISTANCE:   prdata = {11'd0, stop_distance_reg};
                REG_CRUISE_SPEED:    prdata = {16'd0, cruise_speed_reg};
                REG_TURN_RATE_LIMIT: prdata = {17'd0, turn_rate_limit_reg};
                default:             prdata = '0;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // The output register is the only place a result waits; the pipeline
    // advances whenever it is empty or being drained.
    logic en;
    logic out_valid_reg;
    assign en           = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = en;
    assign out_ch.valid = out_valid_reg;

    // ---------------- stage 0: pre-rotation ----------------
    cst_t s0_next, s0_reg;
    always_comb
    begin
        logic signed [VW-1:0] dx, dy;
        logic signed [ZW-1:0] rz0;
        dx = VW'(in_ch.target_x) - VW'(in_ch.pose_x);
        dy = VW'(in_ch.target_y) - VW'(in_ch.pose_y);
        rz0 = -(ZW'(in_ch.heading) <<< 11);
        s0_next.v = in_ch.valid;
        s0_next.h = in_ch.heading;
        s0_next.x = dx;
        s0_next.y = dy;
        s0_next.z = '0;
        if (dx < 0)
        begin
            s0_next.x = -dx;
            s0_next.y = -dy;
            s0_next.z = (dy >= 0) ? PI24 : -PI24;
        end
        s0_next.rx = dx;
        s0_next.ry = dy;
        s0_next.rz = rz0;
        if (rz0 > HALFPI24)
        begin
            s0_next.rx = -dx;
            s0_next.ry = -dy;
            s0_next.rz = rz0 - PI24;
        end
        else if (rz0 < -HALFPI24)
        begin
            s0_next.rx = -dx;
            s0_next.ry = -dy;
            s0_next.rz = rz0 + PI24;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_reg <= '0;
        else if (en)
            s0_reg <= s0_next;
    end

    // ---------------- CORDIC stages ----------------
    // A zero vector stays zero through vectoring, with z held at zero.
    cst_t cs_reg [NS];
    cst_t cs_in  [NS];
    cst_t cs_next [NS];

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            logic signed [VW-1:0] xs, ys, rxs, rys;
            logic zero_vec;
            cs_in[i] = (i == 0) ? s0_reg : cs_reg[i-1];
            cs_next[i] = cs_in[i];
            xs  = cs_in[i].x >>> i;
            ys  = cs_in[i].y >>> i;
            rxs = cs_in[i].rx >>> i;
            rys = cs_in[i].ry >>> i;
            zero_vec = (cs_in[i].x == '0) && (cs_in[i].y == '0);
            if (!zero_vec)
            begin
                if (cs_in[i].y < 0)
                begin
                    cs_next[i].x = cs_in[i].x - ys;
                    cs_next[i].y = cs_in[i].y + xs;
                    cs_next[i].z = cs_in[i].z - atan_entry(i);
                end
                else
                begin
                    cs_next[i].x = cs_in[i].x + ys;
                    cs_next[i].y = cs_in[i].y - xs;
                    cs_next[i].z = cs_in[i].z + atan_entry(i);
                end
            end
            if (cs_in[i].rz >= 0)
            begin
                cs_next[i].rx = cs_in[i].rx - rys;
                cs_next[i].ry = cs_in[i].ry + rxs;
                cs_next[i].rz = cs_in[i].rz - atan_entry(i);
            end
            else
            begin
                cs_next[i].rx = cs_in[i].rx + rys;
                cs_next[i].ry = cs_in[i].ry - rxs;
                cs_next[i].rz = cs_in[i].rz + atan_entry(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                cs_reg[i] <= '0;
        end
        else if (en)
        begin
            for (int i = 0; i < NS; i++)
                cs_reg[i] <= cs_next[i];
        end
    end

    // ---------------- stage A: gain removal, bearing ----------------
    cst_t cl;
    assign cl = cs_reg[NS-1];

    logic        a_v_reg;
    logic [34:0] a_mag_reg, a_ax_reg, a_ay_reg;
    logic        a_rxneg_reg, a_ryneg_reg;
    logic signed [ZW:0] a_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (en)
            a_v_reg <= cl.v;
    end
    always_ff @(posedge clk)
    begin
        logic [34:0] mrx, mry;
        if (en)
        begin
            mrx = cl.rx[VW-1] ? 35'(-cl.rx) : 35'(cl.rx);
            mry = cl.ry[VW-1] ? 35'(-cl.ry) : 35'(cl.ry);
            a_mag_reg   <= unscale(35'(cl.x));
            a_ax_reg    <= unscale(mrx);
            a_ay_reg    <= unscale(mry);
            a_rxneg_reg <= cl.rx[VW-1];
            a_ryneg_reg <= cl.ry[VW-1];
            a_b_reg     <= (ZW+1)'(cl.z) - ((ZW+1)'(cl.h) <<< 11);
        end
    end

    // ---------------- stage B: wrap, kind, distance, normalize ----------------
    logic        b_v_reg;
    logic [1:0]  b_kind_reg;
    logic signed [31:0] b_dist_reg;
    logic signed [15:0] b_bq_reg;
    logic [29:0] b_ax_reg, b_ay_reg;
    logic [2:0]  b_k_reg;
    logic        b_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (en)
            b_v_reg <= a_v_reg;
    end
    always_ff @(posedge clk)
    begin
        logic signed [ZW:0]  bw;
        logic signed [ZW:0]  br;
        logic signed [15:0]  bq;
        logic [2:0]          k;
        logic [34:0]         mx;
        if (en)
        begin
            // |b| stays below 3*pi, so at most one correction applies.
            bw = a_b_reg;
            if (bw > (ZW+1)'(PI24))
                bw = bw - TWOPI24;
            else if (bw < -(ZW+1)'(PI24))
                bw = bw + TWOPI24;
            br = (bw + (ZW+1)'(1024)) >>> 11;
            bq = 16'(br);
            b_bq_reg <= bq;
            if (a_mag_reg <= 35'(stop_distance_reg))
                b_kind_reg <= KIND_STOP;
            else if (bq >= HALFPI_Q13 || bq <= -HALFPI_Q13)
                b_kind_reg <= (bq >= 0) ? KIND_CCW : KIND_CW;
            else
                b_kind_reg <= KIND_FORWARD;
            if (a_rxneg_reg)
                b_dist_reg <= (a_mag_reg > 35'h080000000) ? 32'sh80000000
                                                          : 32'(-a_mag_reg);
            else
                b_dist_reg <= (a_mag_reg > 35'h07FFFFFFF) ? 32'sh7FFFFFFF
                                                          : 32'(a_mag_reg);
            mx = a_ax_reg | a_ay_reg;
            k = 3'd0;
            for (int j = 5; j >= 1; j--)
                if (k == 3'd0 && (mx >> 30) >= 35'(1 << (j - 1)))
                    k = 3'(j);
            b_k_reg  <= k;
            b_ax_reg <= 30'(a_ax_reg >> k);
            b_ay_reg <= 30'(a_ay_reg >> k);
            b_neg_reg <= cruise_speed_reg[15] != a_ryneg_reg;
        end
    end

    // ---------------- stage C: squares, numerator ----------------
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] span;
        logic signed [15:0] bq;
        logic signed [15:0] fs;
        logic               neg;
    } side_t;

    logic        c_v_reg;
    logic [61:0] c_d2_reg;
    logic [62:0] c_num_reg;
    side_t       c_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (en)
            c_v_reg <= b_v_reg;
    end
    always_ff @(posedge clk)
    begin
        logic [15:0] ms;
        logic [45:0] p;
        if (en)
        begin
            ms = cruise_speed_reg[15] ? 16'(-cruise_speed_reg) : cruise_speed_reg;
            p  = 46'(ms) * 46'(b_ay_reg);
            c_num_reg <= 63'({17'd0, p} << (5'd17 - 5'(b_k_reg)));
            c_d2_reg  <= 62'(b_ax_reg) * 62'(b_ax_reg) + 62'(b_ay_reg) * 62'(b_ay_reg);
            c_side_reg <= '{kind: b_kind_reg, span: b_dist_reg, bq: b_bq_reg,
                            fs: cruise_speed_reg, neg: b_neg_reg};
        end
    end

    // ---------------- divider and side-band delay ----------------
    logic        dv_valid;
    logic [62:0] dv_quo;
    logic [61:0] den;
    assign den = (c_d2_reg == '0) ? 62'd1 : c_d2_reg;

    ppms_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_v_reg),
        .num       ((c_d2_reg == '0) ? 63'd0 : c_num_reg),
        .den       (den),
        .out_valid (dv_valid),
        .quo       (dv_quo)
    );

    side_t side_dly_reg [63];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dly_reg[0] <= c_side_reg;
            for (int i = 1; i < 63; i++)
                side_dly_reg[i] <= side_dly_reg[i-1];
        end
    end

    // ---------------- output register ----------------
    logic [1:0]         kind_reg;
    logic signed [31:0] dist_reg;
    logic signed [15:0] bq_reg, fs_reg, ts_reg;
    logic [14:0]        qc;
    side_t              sd;

    assign sd = side_dly_reg[62];
    assign qc = (dv_quo > 63'(turn_rate_limit_reg)) ? turn_rate_limit_reg
                                                    : dv_quo[14:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg <= sd.kind;
            dist_reg <= sd.span;
            bq_reg   <= sd.bq;
            fs_reg   <= sd.fs;
            ts_reg   <= sd.neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        end
    end

    assign out_ch.motion_kind     = kind_reg;
    assign out_ch.signed_distance = dist_reg;
    assign out_ch.bearing_error   = bq_reg;
    assign out_ch.forward_speed   = fs_reg;
    assign out_ch.turn_speed      = ts_reg;

    // ---------------- assertions ----------------
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(ts_reg))
        else $error("result lost during stall");
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_STOP |-> dist_reg <= $signed({11'd0, stop_distance_reg})
            && dist_reg >= -$signed({11'd0, stop_distance_reg}))
        else $error("stop issued beyond threshold");
    a_lim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ts_reg <= $signed({1'b0, turn_rate_limit_reg})
            && ts_reg >= -$signed({1'b0, turn_rate_limit_reg}))
        else $error("turn speed over limit");
endmodule
